// ===== hw/rtl/mkv_pkg.sv =====
// Shared constants and types of the manifest key/value extractor.
package mkv_pkg;

    localparam int KEY_MAX    = 32;
    localparam int VALUE_MAX  = 64;
    localparam int KEY_BYTES  = 32;
    localparam int KEY_WORDS  = 4;
    localparam int KIDX_W     = 5;
    localparam int KLEN_W     = 6;
    localparam int DATA_W     = 64;
    localparam int WIN_DEPTH  = KEY_MAX + 1;
    localparam int SEEN_MAX   = KEY_MAX + 2;
    localparam int SEEN_W     = $clog2(SEEN_MAX + 1);
    localparam int VIDX_W     = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
    localparam int VCNT_W     = $clog2(VALUE_MAX + 1);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STORE = 2'd1,
        CMD_EMIT  = 2'd2,
        CMD_EMPTY = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } cmd_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== hw/rtl/manifest_key_value_extractor_top.sv =====
// Top level of the manifest key/value extractor: front end, command queue and back end.
// The block takes one text byte per cycle on the s_ channel; a zero byte ends a document.
// It finds the first place where the configured key is followed by ": ", captures the value
// up to the next newline (carriage returns dropped, at most 64 bytes kept, longer values
// flagged as truncated) and sends it on the m_ channel one word per cycle while m_ready is
// high, read from the value memory through its registered read port. A document that ends
// before a match or before that newline gives one empty word. With the queue empty and the
// back end idle, a byte's command is registered in the queue and then in the back-end state.
// A four-entry command queue separates byte scanning from result delivery; s_ready drops when
// that queue is full, which happens while the back end is sending a value burst or the output
// is stalled. It is also low in the first cycle after reset. Each configuration write holds
// s_ready low for the following cycle while the key is aligned to the match window.
module manifest_key_value_extractor_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_text_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_value_byte,
    output logic                           m_value_last,
    output logic                           m_value_empty,
    output logic                           m_value_truncated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mkv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mkv_pkg::DATA_W-1:0]     cfg_data
);

    mkv_pkg::q_stat_t    q_stat;
    mkv_pkg::cmd_word_t  q_wr_word;
    mkv_pkg::cmd_word_t  q_rd_word;
    logic                q_push;
    logic                q_pop;

    mkv_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_entry     (q_wr_word)
    );

    mkv_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_word (q_wr_word),
        .pop     (q_pop),
        .rd_word (q_rd_word),
        .stat    (q_stat)
    );

    mkv_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_stat            (q_stat),
        .q_entry           (q_rd_word),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_value_byte      (m_value_byte),
        .m_value_last      (m_value_last),
        .m_value_empty     (m_value_empty),
        .m_value_truncated (m_value_truncated)
    );

endmodule

// ===== hw/rtl/mkv_front.sv =====
// Front end: key registers, match window and byte classification into commands.
module mkv_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_text_byte,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mkv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mkv_pkg::DATA_W-1:0]         cfg_data,
    input  mkv_pkg::q_stat_t                   q_stat,
    output logic                               q_push,
    output mkv_pkg::cmd_word_t                 q_entry
);

    typedef enum logic [2:0] {
        M_SEARCH  = 3'b001,
        M_CAPTURE = 3'b010,
        M_DONE    = 3'b100
    } mode_t;

    logic [mkv_pkg::DATA_W-1:0] key_words_reg [mkv_pkg::KEY_WORDS];
    logic [mkv_pkg::KLEN_W-1:0] key_len_reg;
    logic                       pend_reg;

    logic [7:0]                 pat_reg  [mkv_pkg::KEY_MAX];
    logic [7:0]                 pat_next [mkv_pkg::KEY_MAX];
    logic [mkv_pkg::KEY_MAX-1:0] care_reg;
    logic [mkv_pkg::KEY_MAX-1:0] care_next;
    logic [mkv_pkg::SEEN_W-1:0] lenp2_reg;
    logic [mkv_pkg::SEEN_W-1:0] lenp2_next;

    logic [7:0]                 kb [mkv_pkg::KEY_BYTES];
    logic [mkv_pkg::KLEN_W-1:0] len_eff;

    logic [7:0]                 win_reg [mkv_pkg::WIN_DEPTH];
    logic                       win_shift;
    mode_t                      mode_reg;
    mode_t                      mode_next;
    logic [mkv_pkg::SEEN_W-1:0] seen_reg;
    logic [mkv_pkg::SEEN_W-1:0] seen_next;
    logic [mkv_pkg::SEEN_W-1:0] seen_inc;
    logic [mkv_pkg::KEY_MAX-1:0] hit;
    logic                       match;
    logic                       acc;

    assign cfg_ready = 1'b1;
    assign s_ready   = !pend_reg && !q_stat.full;
    assign acc       = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_words_reg[0] <= '0;
            key_words_reg[1] <= '0;
            key_words_reg[2] <= '0;
            key_words_reg[3] <= '0;
            key_len_reg      <= mkv_pkg::KLEN_W'(1);
            pend_reg         <= 1'b1;
        end else begin
            pend_reg <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    mkv_pkg::CFG_KEY_0:   key_words_reg[0] <= cfg_data;
                    mkv_pkg::CFG_KEY_1:   key_words_reg[1] <= cfg_data;
                    mkv_pkg::CFG_KEY_2:   key_words_reg[2] <= cfg_data;
                    mkv_pkg::CFG_KEY_3:   key_words_reg[3] <= cfg_data;
                    mkv_pkg::CFG_KEY_LEN: key_len_reg <= cfg_data[mkv_pkg::KLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // The key is laid out against the window once per configuration change.
    always_comb begin
        for (int i = 0; i < mkv_pkg::KEY_BYTES; i++) begin
            kb[i] = key_words_reg[i >> 3][8 * (i & 7) +: 8];
        end
        len_eff = (key_len_reg > mkv_pkg::KLEN_W'(mkv_pkg::KEY_MAX))
                ? mkv_pkg::KLEN_W'(mkv_pkg::KEY_MAX) : key_len_reg;
        lenp2_next = mkv_pkg::SEEN_W'(len_eff) + mkv_pkg::SEEN_W'(2);
        for (int p = 0; p < mkv_pkg::KEY_MAX; p++) begin
            care_next[p] = mkv_pkg::KLEN_W'(p) < len_eff;
            pat_next[p]  = kb[mkv_pkg::KIDX_W'(len_eff - mkv_pkg::KLEN_W'(p)
                                               - mkv_pkg::KLEN_W'(1))];
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            pat_reg   <= pat_next;
            care_reg  <= care_next;
            lenp2_reg <= lenp2_next;
        end
    end

    always_comb begin
        for (int p = 0; p < mkv_pkg::KEY_MAX; p++) begin
            hit[p] = !care_reg[p] || (win_reg[p + 1] == pat_reg[p]);
        end
        seen_inc = (seen_reg < mkv_pkg::SEEN_W'(mkv_pkg::SEEN_MAX))
                 ? seen_reg + mkv_pkg::SEEN_W'(1) : seen_reg;
        match = (s_text_byte == mkv_pkg::CH_SPACE) && (win_reg[0] == mkv_pkg::CH_COLON)
              && (&hit) && (seen_inc >= lenp2_reg);
    end

    always_comb begin
        mode_next     = mode_reg;
        seen_next     = seen_reg;
        win_shift     = 1'b0;
        q_push        = 1'b0;
        q_entry.cmd   = mkv_pkg::CMD_STORE;
        q_entry.data  = s_text_byte;
        if (acc) begin
            if (s_text_byte == mkv_pkg::CH_NUL) begin
                if (mode_reg == M_SEARCH || mode_reg == M_CAPTURE) begin
                    q_push      = 1'b1;
                    q_entry.cmd = mkv_pkg::CMD_EMPTY;
                end
                mode_next = M_SEARCH;
                seen_next = '0;
            end else begin
                unique case (mode_reg)
                    M_SEARCH: begin
                        win_shift = 1'b1;
                        seen_next = seen_inc;
                        if (match) begin
                            q_push      = 1'b1;
                            q_entry.cmd = mkv_pkg::CMD_START;
                            mode_next   = M_CAPTURE;
                        end
                    end
                    M_CAPTURE: begin
                        if (s_text_byte == mkv_pkg::CH_LF) begin
                            q_push      = 1'b1;
                            q_entry.cmd = mkv_pkg::CMD_EMIT;
                            mode_next   = M_DONE;
                        end else if (s_text_byte != mkv_pkg::CH_CR) begin
                            q_push      = 1'b1;
                            q_entry.cmd = mkv_pkg::CMD_STORE;
                        end
                    end
                    M_DONE: ;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_SEARCH;
            seen_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (win_shift) begin
            win_reg[0] <= s_text_byte;
            for (int i = 1; i < mkv_pkg::WIN_DEPTH; i++) begin
                win_reg[i] <= win_reg[i - 1];
            end
        end
    end

endmodule

// ===== hw/rtl/mkv_fifo.sv =====
// Short command queue between the front end and the back end.
module mkv_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mkv_pkg::cmd_word_t  wr_word,
    input  logic                pop,
    output mkv_pkg::cmd_word_t  rd_word,
    output mkv_pkg::q_stat_t    stat
);

    mkv_pkg::cmd_word_t          mem_reg [mkv_pkg::QDEPTH];
    logic [mkv_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [mkv_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [mkv_pkg::QCNT_W-1:0]  cnt_reg;

    assign stat.full  = cnt_reg == mkv_pkg::QCNT_W'(mkv_pkg::QDEPTH);
    assign stat.empty = cnt_reg == '0;
    assign rd_word    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == mkv_pkg::QPTR_W'(mkv_pkg::QDEPTH - 1))
                            ? '0 : wr_ptr_reg + mkv_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == mkv_pkg::QPTR_W'(mkv_pkg::QDEPTH - 1))
                            ? '0 : rd_ptr_reg + mkv_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + mkv_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - mkv_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("Command pushed into a full queue.");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("Command popped from an empty queue.");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= mkv_pkg::QCNT_W'(mkv_pkg::QDEPTH))
        else $error("Queue fill count out of range.");
`endif

endmodule

// ===== hw/rtl/mkv_back.sv =====
// Back end: value capture memory and result word sequencer.
module mkv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  mkv_pkg::q_stat_t    q_stat,
    input  mkv_pkg::cmd_word_t  q_entry,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_value_byte,
    output logic                m_value_last,
    output logic                m_value_empty,
    output logic                m_value_truncated
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_SEND  = 3'b010,
        B_EMPTY = 3'b100
    } bstate_t;

    logic [7:0]                  mem [mkv_pkg::VALUE_MAX];
    logic [7:0]                  rdata_reg;
    bstate_t                     state_reg;
    bstate_t                     state_next;
    logic [mkv_pkg::VIDX_W-1:0]  idx_reg;
    logic [mkv_pkg::VIDX_W-1:0]  idx_next;
    logic [mkv_pkg::VCNT_W-1:0]  cnt_reg;
    logic [mkv_pkg::VCNT_W-1:0]  cnt_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic                        wr_en;
    logic                        is_last;

    assign q_pop   = (state_reg == B_IDLE) && !q_stat.empty;
    assign is_last = (mkv_pkg::VCNT_W'(idx_reg) + mkv_pkg::VCNT_W'(1)) == cnt_reg;

    assign m_valid           = (state_reg == B_SEND) || (state_reg == B_EMPTY);
    assign m_value_byte      = (state_reg == B_SEND) ? rdata_reg : 8'h00;
    assign m_value_last      = (state_reg == B_EMPTY) || is_last;
    assign m_value_empty     = state_reg == B_EMPTY;
    assign m_value_truncated = (state_reg == B_SEND) && ovf_reg;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    unique case (q_entry.cmd)
                        mkv_pkg::CMD_START: begin
                            cnt_next = '0;
                            ovf_next = 1'b0;
                        end
                        mkv_pkg::CMD_STORE: begin
                            if (cnt_reg < mkv_pkg::VCNT_W'(mkv_pkg::VALUE_MAX)) begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + mkv_pkg::VCNT_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        mkv_pkg::CMD_EMIT: begin
                            if (cnt_reg == '0) begin
                                state_next = B_EMPTY;
                            end else begin
                                state_next = B_SEND;
                                idx_next   = '0;
                            end
                        end
                        mkv_pkg::CMD_EMPTY: begin
                            state_next = B_EMPTY;
                        end
                    endcase
                end
            end
            B_SEND: begin
                if (m_ready) begin
                    if (is_last) begin
                        state_next = B_IDLE;
                    end else begin
                        idx_next = idx_reg + mkv_pkg::VIDX_W'(1);
                    end
                end
            end
            B_EMPTY: begin
                if (m_ready) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[mkv_pkg::VIDX_W-1:0]] <= q_entry.data;
        end
        rdata_reg <= mem[idx_next];
    end

`ifndef NO_ASSERTIONS
    a_send_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SEND) |-> (cnt_reg != '0))
        else $error("Value burst started with no captured bytes.");
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SEND) |-> (mkv_pkg::VCNT_W'(idx_reg) < cnt_reg))
        else $error("Value read index beyond captured bytes.");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SEND && !m_ready) |=> (state_reg == B_SEND && $stable(idx_reg)))
        else $error("Value burst moved while the output was stalled.");
`endif

endmodule
